// ===== src/gcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gcd_pkg;

  // iteration counts
  localparam int CORDIC_STEPS = 32;
  localparam int STEP_W = 6;
  localparam int SQ_STEPS = 31;
  localparam int ANG_LAT = 5;
  localparam int LAT = 1 + ANG_LAT + CORDIC_STEPS + 3 + SQ_STEPS + CORDIC_STEPS + 2;

  // datapath widths
  localparam int CW = 34;
  localparam int PW = 2 * CW;
  localparam int ROOT_W = 31;
  localparam int RAD_W = 62;
  localparam int REM_W = 34;

  // fixed-point constants
  localparam logic signed [CW-1:0] GAIN = CW'(652032874);
  localparam logic signed [CW-1:0] Q_ONE = CW'(1073741824);
  localparam logic signed [PW-1:0] RND_P = PW'(536870912);
  localparam logic [31:0] DEG_LO = 32'd3753943213;
  localparam logic signed [32:0] TURN_U = 33'sd3600000000;
  localparam logic signed [32:0] HALF_U = 33'sd1800000000;
  localparam logic signed [32:0] QUART_U = 33'sd900000000;
  localparam logic [30:0] DIST_MAX = 31'd2010619298;
  localparam logic [29:0] RAD100_RST = 30'd637100000;

  // atan(2^-i) in Q4.30
  function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      6'd0: r = CW'(843314857);
      6'd1: r = CW'(497837829);
      6'd2: r = CW'(263043837);
      6'd3: r = CW'(133525159);
      6'd4: r = CW'(67021687);
      6'd5: r = CW'(33543516);
      6'd6: r = CW'(16775851);
      6'd7: r = CW'(8388437);
      6'd8: r = CW'(4194283);
      6'd9: r = CW'(2097149);
      6'd10: r = CW'(1048576);
      default: begin
        if (i <= 6'd30) r = CW'(1) <<< (6'd30 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/great_circle_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Haversine great-circle distance, fully pipelined.
// Input: pulse start with lat_a, lon_a, lat_b, lon_b (1e-7 degree, signed).
//   busy is always low, so a new word may be sent every cycle.
// Output: done is high for one cycle with distance_cm (saturated at
//   2010619298 cm). The receiver cannot stall; every word comes out once.
// Pipeline: input register, 5 angle conversion stages, a row of CORDIC
//   rotation cells (one per step), 3 multiply/sum stages, a row of 31
//   square-root cells (one root bit each), a row of vectoring CORDIC cells,
//   and 2 scaling/output stages.
// Throughput: one word per cycle; each cell handles one step per cycle.
// Configuration: cfg_we with cfg_data sets earth radius in metres; write
//   only while no word is in flight. Reset sets 6371000 m.
// Reset: rst clears the valid pipeline, so no done appears for words that
//   were in flight.
module great_circle_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  input  logic               cfg_we,
  input  logic [22:0]        cfg_data,
  output logic               done,
  output logic [30:0]        distance_cm
);

  localparam int N = gcd_pkg::CORDIC_STEPS;
  localparam int CW = gcd_pkg::CW;
  localparam int PW = gcd_pkg::PW;
  localparam int SQ = gcd_pkg::SQ_STEPS;
  localparam int LAT = gcd_pkg::LAT;

  logic [29:0]          rad100;
  logic [LAT-1:0]       vld;
  logic signed [32:0]   u_q [4];
  logic signed [CW-1:0] ang_rad [4];
  logic                 ang_flip [4];
  logic [1:0]           flip_d [N];

  logic signed [CW-1:0] rot_x [4][N+1];
  logic signed [CW-1:0] rot_y [4][N+1];
  logic signed [CW-1:0] rot_z [4][N+1];

  logic signed [CW-1:0] ca, cb;
  logic signed [PW-1:0] p_cc, p_sa, p_so, p_t;
  logic signed [CW-1:0] cc_q, hsa_q, hso_q, hsa_d, t_q;
  logic signed [CW:0]   a_sum;
  logic [30:0]          a_q, b_q;

  logic [gcd_pkg::REM_W-1:0]  sq_rem [2][SQ+1];
  logic [gcd_pkg::ROOT_W-1:0] sq_root [2][SQ+1];
  logic [gcd_pkg::RAD_W-1:0]  sq_rad [2][SQ+1];

  logic signed [CW-1:0] vx [N+1];
  logic signed [CW-1:0] vy [N+1];
  logic signed [CW-1:0] vz [N+1];

  logic signed [CW:0]   c2;
  logic [31:0]          c_pos;
  logic [61:0]          p_d;
  logic [62:0]          d_sum;
  logic [32:0]          d_val;

  assign busy = 1'b0;

  // radius register, stored pre-scaled to centimetres
  always_ff @(posedge clk) begin
    if (rst) begin
      rad100 <= gcd_pkg::RAD100_RST;
    end else if (cfg_we) begin
      rad100 <= 30'(cfg_data) * 30'd100;
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end
  assign done = vld[LAT-1];

  // input register: angle differences and latitudes
  always_ff @(posedge clk) begin
    u_q[0] <= 33'(lat_a) - 33'(lat_b);
    u_q[1] <= 33'(lon_a) - 33'(lon_b);
    u_q[2] <= 33'(lat_a);
    u_q[3] <= 33'(lat_b);
  end

  // angle conversion and rotation rows
  for (genvar c = 0; c < 4; c++) begin : g_ang
    gcd_angle u_angle (
      .clk  (clk),
      .half ((c < 2) ? 1'b1 : 1'b0),
      .u_in (u_q[c]),
      .rad  (ang_rad[c]),
      .flip (ang_flip[c])
    );
    assign rot_x[c][0] = gcd_pkg::GAIN;
    assign rot_y[c][0] = '0;
    assign rot_z[c][0] = ang_rad[c];
    for (genvar k = 0; k < N; k++) begin : g_rot
      gcd_rot_cell u_cell (
        .clk  (clk),
        .step (gcd_pkg::STEP_W'(k)),
        .x_in (rot_x[c][k]),
        .y_in (rot_y[c][k]),
        .z_in (rot_z[c][k]),
        .x    (rot_x[c][k+1]),
        .y    (rot_y[c][k+1]),
        .z    (rot_z[c][k+1])
      );
    end
  end

  // cosine sign flips travel beside the rotation row
  always_ff @(posedge clk) begin
    flip_d[0] <= {ang_flip[3], ang_flip[2]};
    for (int k = 1; k < N; k++) flip_d[k] <= flip_d[k-1];
  end

  // products: sin^2 terms and cos product
  assign ca = flip_d[N-1][0] ? -rot_x[2][N] : rot_x[2][N];
  assign cb = flip_d[N-1][1] ? -rot_x[3][N] : rot_x[3][N];
  assign p_cc = PW'(ca) * PW'(cb);
  assign p_sa = PW'(rot_y[0][N]) * PW'(rot_y[0][N]);
  assign p_so = PW'(rot_y[1][N]) * PW'(rot_y[1][N]);
  assign p_t = PW'(cc_q) * PW'(hso_q);

  always_ff @(posedge clk) begin
    cc_q <= CW'((p_cc + gcd_pkg::RND_P) >>> 30);
    hsa_q <= CW'((p_sa + gcd_pkg::RND_P) >>> 30);
    hso_q <= CW'((p_so + gcd_pkg::RND_P) >>> 30);
    t_q <= CW'((p_t + gcd_pkg::RND_P) >>> 30);
    hsa_d <= hsa_q;
  end

  // sum and clamp a to [0, 1]
  assign a_sum = (CW+1)'(hsa_d) + (CW+1)'(t_q);
  always_ff @(posedge clk) begin
    if (a_sum < 0) begin
      a_q <= '0;
      b_q <= 31'(gcd_pkg::Q_ONE);
    end else if (a_sum > (CW+1)'(gcd_pkg::Q_ONE)) begin
      a_q <= 31'(gcd_pkg::Q_ONE);
      b_q <= '0;
    end else begin
      a_q <= 31'(a_sum);
      b_q <= 31'((CW+1)'(gcd_pkg::Q_ONE) - a_sum);
    end
  end

  // square-root rows: index 0 is sqrt(a), index 1 is sqrt(1-a)
  assign sq_rad[0][0] = {1'b0, a_q, 30'b0};
  assign sq_rad[1][0] = {1'b0, b_q, 30'b0};
  for (genvar s = 0; s < 2; s++) begin : g_sq
    assign sq_rem[s][0] = '0;
    assign sq_root[s][0] = '0;
    for (genvar k = 0; k < SQ; k++) begin : g_cell
      gcd_sqrt_cell u_cell (
        .clk     (clk),
        .rem_in  (sq_rem[s][k]),
        .root_in (sq_root[s][k]),
        .rad_in  (sq_rad[s][k]),
        .rem     (sq_rem[s][k+1]),
        .root    (sq_root[s][k+1]),
        .rad     (sq_rad[s][k+1])
      );
    end
  end

  // vectoring row: atan2(sqrt(a), sqrt(1-a))
  assign vx[0] = CW'(sq_root[1][SQ]);
  assign vy[0] = CW'(sq_root[0][SQ]);
  assign vz[0] = '0;
  for (genvar k = 0; k < N; k++) begin : g_vec
    gcd_vec_cell u_cell (
      .clk  (clk),
      .step (gcd_pkg::STEP_W'(k)),
      .x_in (vx[k]),
      .y_in (vy[k]),
      .z_in (vz[k]),
      .x    (vx[k+1]),
      .y    (vy[k+1]),
      .z    (vz[k+1])
    );
  end

  // scale central angle by radius, round and saturate
  assign c2 = (CW+1)'(vz[N]) <<< 1;
  assign c_pos = (c2 < 0) ? '0 : c2[31:0];
  assign d_sum = 63'(p_d) + 63'(536870912);
  assign d_val = d_sum[62:30];

  always_ff @(posedge clk) begin
    p_d <= 62'(rad100) * 62'(c_pos);
    distance_cm <= (d_val > 33'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : d_val[30:0];
  end

endmodule
`default_nettype wire

// ===== src/gcd_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcd_angle (
  input  logic                           clk,
  input  logic                           half,
  input  logic signed [32:0]             u_in,
  output logic signed [gcd_pkg::CW-1:0]  rad,
  output logic                           flip
);

  logic signed [32:0] w1, w2;
  logic signed [32:0] w_c, f_c;
  logic               f2, f3, f4;
  logic               f_fl;
  logic [30:0]        mag3, mag4;
  logic               neg3, neg4;
  logic [62:0]        plo;
  logic [64:0]        sum;
  logic [30:0]        r;

  // wrap into one turn
  always_comb begin
    w_c = u_in;
    if (u_in >= gcd_pkg::HALF_U) w_c = u_in - gcd_pkg::TURN_U;
    else if (u_in < -gcd_pkg::HALF_U) w_c = u_in + gcd_pkg::TURN_U;
  end

  // fold full angles into +-90 degrees
  always_comb begin
    f_c = w1;
    f_fl = 1'b0;
    if (!half && w1 > gcd_pkg::QUART_U) begin
      f_c = w1 - gcd_pkg::HALF_U;
      f_fl = 1'b1;
    end else if (!half && w1 < -gcd_pkg::QUART_U) begin
      f_c = w1 + gcd_pkg::HALF_U;
      f_fl = 1'b1;
    end
  end

  // degrees to radians: mag * (2^32 + DEG_LO), rounded
  always_comb begin
    sum = {2'b00, mag4, 32'b0} + {2'b00, plo} + (half ? 65'd4294967296 : 65'd2147483648);
    r = half ? sum[63:33] : sum[62:32];
  end

  always_ff @(posedge clk) begin
    w1 <= w_c;
    w2 <= f_c;
    f2 <= f_fl;
    neg3 <= w2[32];
    mag3 <= w2[32] ? 31'(-w2) : w2[30:0];
    f3 <= f2;
    plo <= 63'(mag3) * 63'(gcd_pkg::DEG_LO);
    mag4 <= mag3;
    neg4 <= neg3;
    f4 <= f3;
    rad <= neg4 ? -gcd_pkg::CW'(r) : gcd_pkg::CW'(r);
    flip <= f4;
  end

endmodule
`default_nettype wire

// ===== src/gcd_rot_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcd_rot_cell (
  input  logic                              clk,
  input  logic [gcd_pkg::STEP_W-1:0]        step,
  input  logic signed [gcd_pkg::CW-1:0]     x_in,
  input  logic signed [gcd_pkg::CW-1:0]     y_in,
  input  logic signed [gcd_pkg::CW-1:0]     z_in,
  output logic signed [gcd_pkg::CW-1:0]     x,
  output logic signed [gcd_pkg::CW-1:0]     y,
  output logic signed [gcd_pkg::CW-1:0]     z
);

  logic signed [gcd_pkg::CW-1:0] xs, ys, at;

  assign xs = x_in >>> step;
  assign ys = y_in >>> step;
  assign at = gcd_pkg::atan_q30(step);

  // rotate toward z = 0
  always_ff @(posedge clk) begin
    if (z_in >= 0) begin
      x <= x_in - ys;
      y <= y_in + xs;
      z <= z_in - at;
    end else begin
      x <= x_in + ys;
      y <= y_in - xs;
      z <= z_in + at;
    end
  end

endmodule
`default_nettype wire

// ===== src/gcd_vec_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcd_vec_cell (
  input  logic                              clk,
  input  logic [gcd_pkg::STEP_W-1:0]        step,
  input  logic signed [gcd_pkg::CW-1:0]     x_in,
  input  logic signed [gcd_pkg::CW-1:0]     y_in,
  input  logic signed [gcd_pkg::CW-1:0]     z_in,
  output logic signed [gcd_pkg::CW-1:0]     x,
  output logic signed [gcd_pkg::CW-1:0]     y,
  output logic signed [gcd_pkg::CW-1:0]     z
);

  logic signed [gcd_pkg::CW-1:0] xs, ys, at;

  assign xs = x_in >>> step;
  assign ys = y_in >>> step;
  assign at = gcd_pkg::atan_q30(step);

  // rotate toward y = 0, accumulate angle
  always_ff @(posedge clk) begin
    if (y_in >= 0) begin
      x <= x_in + ys;
      y <= y_in - xs;
      z <= z_in + at;
    end else begin
      x <= x_in - ys;
      y <= y_in + xs;
      z <= z_in - at;
    end
  end

endmodule
`default_nettype wire

// ===== src/gcd_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcd_sqrt_cell (
  input  logic                           clk,
  input  logic [gcd_pkg::REM_W-1:0]      rem_in,
  input  logic [gcd_pkg::ROOT_W-1:0]     root_in,
  input  logic [gcd_pkg::RAD_W-1:0]      rad_in,
  output logic [gcd_pkg::REM_W-1:0]      rem,
  output logic [gcd_pkg::ROOT_W-1:0]     root,
  output logic [gcd_pkg::RAD_W-1:0]      rad
);

  logic [gcd_pkg::REM_W-1:0] rem_sh, trial;

  // one root bit per cell
  assign rem_sh = {rem_in[gcd_pkg::REM_W-3:0], rad_in[gcd_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_in, 2'b01};

  always_ff @(posedge clk) begin
    rad <= {rad_in[gcd_pkg::RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem <= rem_sh - trial;
      root <= {root_in[gcd_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem <= rem_sh;
      root <= {root_in[gcd_pkg::ROOT_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

// ===== src/gcd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [30:0] distance_cm
);

  // the pipeline never refuses a word
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every accepted word yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(gcd_pkg::LAT) done)
    else $error("result missing after accept");

  // results stay within the saturation bound
  a_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (distance_cm <= gcd_pkg::DIST_MAX))
    else $error("distance above bound");

  // no result the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result after reset");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .distance_cm (distance_cm)
);
`default_nettype wire
